// ===== src/stev_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stev_pkg
// shared types and constants for the soft timer event unit
// ----------------------------------------------------------------------------
package stev_pkg;
    localparam int TaskCountDef  = 8;
    localparam int TimerCountDef = 8;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_SET      = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;
    localparam logic [2:0] OP_DISPATCH = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  timer_index;
        logic [3:0]  task_index;
        logic [15:0] timeout;
        logic [15:0] period;
        logic [31:0] event_bits;
        logic [15:0] elapsed;
    } t_item;

    typedef struct packed {
        logic        status;
        logic        event_valid;
        logic [2:0]  served_task;
        logic [4:0]  event_number;
        logic [31:0] event_mask_out;
        logic        last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture item
        logic simple;    // apply non-tick, non-dispatch item
        logic tick_step; // process timer at walk index
        logic scan_step; // test task at walk index
        logic bit_step;  // emit one event bit
        logic walk_clr;  // reset walk index
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] opcode;
        logic       walk_done;
        logic       task_hit;
        logic       bits_done;
    } t_stat;
endpackage
`default_nettype wire

// ===== src/stev_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stev_item_if / stev_result_if
// valid-ready channels for input items and results
// ----------------------------------------------------------------------------
interface stev_item_if;
    logic            valid;
    logic            ready;
    stev_pkg::t_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface stev_result_if;
    logic              valid;
    logic              ready;
    stev_pkg::t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/stev_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stev_datapath
// timer table, pending words, walk index and result formation
// ----------------------------------------------------------------------------
module stev_datapath #(
    parameter int TASK_COUNT  = stev_pkg::TaskCountDef,
    parameter int TIMER_COUNT = stev_pkg::TimerCountDef
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire [7:0]               i_cfg_data,
    input  wire stev_pkg::t_item    i_item,
    input  wire stev_pkg::t_cmd     i_cmd,
    output stev_pkg::t_stat         o_stat,
    output stev_pkg::t_result       o_simple_res,
    output stev_pkg::t_result       o_bit_res
);
    localparam int WalkMax = (TASK_COUNT > TIMER_COUNT) ? TASK_COUNT : TIMER_COUNT;
    localparam int WW = $clog2(WalkMax + 1);
    localparam int TmW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int TkW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    logic [7:0]  r_hmask;
    stev_pkg::t_item r_item;
    logic [TIMER_COUNT-1:0] r_run;
    logic [15:0] r_remain [TIMER_COUNT];
    logic [15:0] r_reload [TIMER_COUNT];
    logic [31:0] r_events [TIMER_COUNT];
    logic [3:0]  r_target [TIMER_COUNT];
    logic [31:0] r_pend   [TASK_COUNT];
    logic [WW-1:0] r_walk;
    logic [31:0] r_ev;
    logic [3:0]  r_task;

    logic [3:0]  tmr_i;
    logic [3:0]  tsk_i;
    logic        tmr_ok;
    logic        tsk_ok;
    logic [31:0] low_bit;
    logic [4:0]  low_num;
    logic [3:0]  walk4;
    logic        walk_task_hit;
    logic [TmW-1:0] tmr_sel;
    logic [TkW-1:0] tsk_sel;
    logic [TmW-1:0] walk_tm;
    logic [TkW-1:0] walk_tk;
    logic [TkW-1:0] tgt_sel;

    assign tmr_i  = r_item.timer_index;
    assign tsk_i  = r_item.task_index;
    assign tmr_ok = 32'(tmr_i) < TIMER_COUNT;
    assign tsk_ok = 32'(tsk_i) < TASK_COUNT;
    assign walk4  = 4'(r_walk);
    assign tmr_sel = TmW'(tmr_i);
    assign tsk_sel = TkW'(tsk_i);
    assign walk_tm = TmW'(walk4);
    assign walk_tk = TkW'(walk4);
    assign tgt_sel = TkW'(r_target[walk_tm]);
    assign low_bit = r_ev & (~r_ev + 32'd1);

    always_comb begin
        low_num = '0;
        for (int b = 31; b >= 0; b--) begin
            if (r_ev[b]) begin
                low_num = 5'(b);
            end
        end
    end

    assign walk_task_hit = (32'(r_walk) < TASK_COUNT) && (walk4 < 4'd8)
        && (r_pend[walk_tk] != '0)
        && r_hmask[walk4[2:0]];

    always_comb begin
        o_stat.opcode    = r_item.opcode;
        o_stat.walk_done = (r_item.opcode == stev_pkg::OP_TICK)
            ? (32'(r_walk) >= TIMER_COUNT - 1 || r_item.elapsed == '0)
            : (32'(r_walk) >= TASK_COUNT - 1);
        o_stat.task_hit  = walk_task_hit;
        o_stat.bits_done = (r_ev & ~low_bit) == '0;
    end

    always_comb begin
        o_simple_res = '0;
        o_simple_res.last = 1'b1;
        case (r_item.opcode)
            stev_pkg::OP_START, stev_pkg::OP_STOP: o_simple_res.status = ~tmr_ok;
            stev_pkg::OP_SET, stev_pkg::OP_CLEAR:  o_simple_res.status = ~tsk_ok;
            default: o_simple_res.status = 1'b0;
        endcase
        o_bit_res.status         = 1'b0;
        o_bit_res.event_valid    = 1'b1;
        o_bit_res.served_task    = r_task[2:0];
        o_bit_res.event_number   = low_num;
        o_bit_res.event_mask_out = low_bit;
        o_bit_res.last           = (r_ev & ~low_bit) == '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (!i_rst_n) begin
            r_hmask <= '0;
            r_run   <= '0;
            r_walk  <= '0;
            for (int i = 0; i < TIMER_COUNT; i++) begin
                r_remain[i] <= '0;
                r_reload[i] <= '0;
                r_events[i] <= '0;
                r_target[i] <= '0;
            end
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_pend[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_hmask <= i_cfg_data;
            end
            if (i_cmd.walk_clr) begin
                r_walk <= '0;
            end
            if (i_cmd.simple) begin
                case (r_item.opcode)
                    stev_pkg::OP_START: begin
                        if (tmr_ok) begin
                            r_run[tmr_sel]    <= 1'b1;
                            r_remain[tmr_sel] <= r_item.timeout;
                            r_reload[tmr_sel] <= r_item.period;
                            r_target[tmr_sel] <= tsk_i;
                            r_events[tmr_sel] <= r_item.event_bits;
                        end
                    end
                    stev_pkg::OP_STOP: begin
                        if (tmr_ok) begin
                            r_run[tmr_sel]    <= 1'b0;
                            r_events[tmr_sel] <= '0;
                        end
                    end
                    stev_pkg::OP_SET: begin
                        if (tsk_ok) begin
                            r_pend[tsk_sel] <= r_pend[tsk_sel] | r_item.event_bits;
                        end
                    end
                    stev_pkg::OP_CLEAR: begin
                        if (tsk_ok) begin
                            r_pend[tsk_sel] <= r_pend[tsk_sel] & ~r_item.event_bits;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.tick_step) begin
                r_walk <= r_walk + 1'b1;
                if (r_item.elapsed != '0 && r_run[walk_tm]) begin
                    if (r_remain[walk_tm] > r_item.elapsed) begin
                        r_remain[walk_tm] <= r_remain[walk_tm] - r_item.elapsed;
                    end else begin
                        if (32'(r_target[walk_tm]) < TASK_COUNT) begin
                            r_pend[tgt_sel] <= r_pend[tgt_sel] | r_events[walk_tm];
                        end
                        if (r_reload[walk_tm] != '0) begin
                            r_remain[walk_tm] <= r_reload[walk_tm];
                        end else begin
                            r_events[walk_tm] <= '0;
                            r_run[walk_tm]    <= 1'b0;
                        end
                    end
                end
            end
            if (i_cmd.scan_step) begin
                r_walk <= r_walk + 1'b1;
                if (walk_task_hit) begin
                    r_ev   <= r_pend[walk_tk];
                    r_task <= walk4;
                    r_pend[walk_tk] <= '0;
                end
            end
            if (i_cmd.bit_step) begin
                r_ev <= r_ev & ~low_bit;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bit_step |-> $onehot(low_bit))
        else $error("emitted mask not one-hot");
    a_scan_only_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> r_item.opcode == stev_pkg::OP_DISPATCH)
        else $error("task scan outside dispatch");
    a_tick_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_step |-> r_item.opcode == stev_pkg::OP_TICK)
        else $error("timer walk outside tick");
`endif
endmodule
`default_nettype wire

// ===== src/stev_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stev_ctrl
// sequencer for item intake, timer walk, task scan and event output
// ----------------------------------------------------------------------------
module stev_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_out_is_bit,
    input  wire stev_pkg::t_stat i_stat,
    output stev_pkg::t_cmd      o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_TICK = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_BITS = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready   = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid  = (r_state == S_RES) || (r_state == S_BITS);
    assign o_out_is_bit = r_state == S_BITS;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    o_cmd.walk_clr = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.opcode)
                    stev_pkg::OP_TICK:     n_state = S_TICK;
                    stev_pkg::OP_DISPATCH: n_state = S_SCAN;
                    default: begin
                        o_cmd.simple = 1'b1;
                        n_state = S_RES;
                    end
                endcase
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_RES;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.task_hit) begin
                    n_state = S_BITS;
                end else if (i_stat.walk_done) begin
                    n_state = S_RES;
                end
            end
            S_BITS: begin
                if (i_out_ready) begin
                    o_cmd.bit_step = 1'b1;
                    if (i_stat.bits_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RES: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_intake_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> $past(r_state) != S_RES || r_state == S_IDLE)
        else $error("intake while busy");
    a_one_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.tick_step, o_cmd.scan_step, o_cmd.bit_step, o_cmd.simple}))
        else $error("conflicting commands");
    a_out_not_ready_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("intake during result");
`endif
endmodule
`default_nettype wire

// ===== src/soft_timer_event_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soft_timer_event_unit
// timer table posting event bits to per-task pending words, with dispatch
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one command per transaction; out_ch returns results.
//   start, stop, set, clear and unused opcodes: applied in the decode
//     state, then one result from the result state.
//   tick: walks every timer, one per cycle; zero elapsed ends after the
//     first step. dispatch: scans tasks one per cycle until the first
//     served task (one result with no event if none), then emits one
//     result per pending bit, lowest first, one per cycle unless stalled.
//   one item is handled at a time; in_ch ready is low during reset and
//   until the last result has been taken.
//   a stalled receiver holds the current result and the next item waits.
//   reset (synchronous, active low) stops all timers, clears all pending
//   words and the handler mask; the mask is written via i_cfg_we.
// ----------------------------------------------------------------------------
module soft_timer_event_unit #(
    parameter int TASK_COUNT  = stev_pkg::TaskCountDef,
    parameter int TIMER_COUNT = stev_pkg::TimerCountDef
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_data,
    stev_item_if.sink     in_ch,
    stev_result_if.source out_ch
);
    stev_pkg::t_cmd    cmd;
    stev_pkg::t_stat   stat;
    stev_pkg::t_result simple_res;
    stev_pkg::t_result bit_res;
    logic              out_is_bit;

    stev_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .o_in_ready   (in_ch.ready),
        .o_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .o_out_is_bit (out_is_bit),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    stev_datapath #(
        .TASK_COUNT  (TASK_COUNT),
        .TIMER_COUNT (TIMER_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_item       (in_ch.payload),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_simple_res (simple_res),
        .o_bit_res    (bit_res)
    );

    assign out_ch.payload = out_is_bit ? bit_res : simple_res;
endmodule
`default_nettype wire
